@@ rtl/core/ctc_pkg.sv @@
package ctc_pkg;

    localparam int KW_COUNT = 32;
    localparam int OP_COUNT = 38;
    localparam int KW_CHARS = 9;
    localparam int OP_CHARS = 3;

    typedef logic [2:0] class_t;
    typedef logic [2:0] err_t;

    localparam class_t CLS_KEYWORD = 3'd0;
    localparam class_t CLS_IDENT   = 3'd1;
    localparam class_t CLS_CONST   = 3'd2;
    localparam class_t CLS_BAD     = 3'd3;
    localparam class_t CLS_OPER    = 3'd4;
    localparam class_t CLS_SPECIAL = 3'd5;
    localparam class_t CLS_UNKNOWN = 3'd6;

    localparam err_t ERR_NONE = 3'd0;
    localparam err_t ERR_CHAR = 3'd1;
    localparam err_t ERR_HEX  = 3'd2;
    localparam err_t ERR_BIN  = 3'd3;
    localparam err_t ERR_OCT  = 3'd4;
    localparam err_t ERR_NUM  = 3'd5;

    function automatic logic [71:0] kw_word(input logic [4:0] idx);
        logic [71:0] w;
        case (idx)
            5'd0:  w = {"auto", 40'h0};
            5'd1:  w = {"break", 32'h0};
            5'd2:  w = {"case", 40'h0};
            5'd3:  w = {"char", 40'h0};
            5'd4:  w = {"const", 32'h0};
            5'd5:  w = {"continue", 8'h0};
            5'd6:  w = {"default", 16'h0};
            5'd7:  w = {"do", 56'h0};
            5'd8:  w = {"double", 24'h0};
            5'd9:  w = {"else", 40'h0};
            5'd10: w = {"enum", 40'h0};
            5'd11: w = {"extern", 24'h0};
            5'd12: w = {"float", 32'h0};
            5'd13: w = {"for", 48'h0};
            5'd14: w = {"goto", 40'h0};
            5'd15: w = {"if", 56'h0};
            5'd16: w = {"int", 48'h0};
            5'd17: w = {"long", 40'h0};
            5'd18: w = {"register", 8'h0};
            5'd19: w = {"return", 24'h0};
            5'd20: w = {"short", 32'h0};
            5'd21: w = {"signed", 24'h0};
            5'd22: w = {"sizeof", 24'h0};
            5'd23: w = {"static", 24'h0};
            5'd24: w = {"struct", 24'h0};
            5'd25: w = {"switch", 24'h0};
            5'd26: w = {"typedef", 16'h0};
            5'd27: w = {"union", 32'h0};
            5'd28: w = {"unsigned", 8'h0};
            5'd29: w = {"void", 40'h0};
            5'd30: w = {"volatile", 8'h0};
            default: w = {"while", 32'h0};
        endcase
        return w;
    endfunction

    function automatic logic [23:0] op_word(input logic [5:0] idx);
        logic [23:0] w;
        case (idx)
            6'd0:  w = {"+", 16'h0};
            6'd1:  w = {"-", 16'h0};
            6'd2:  w = {"*", 16'h0};
            6'd3:  w = {"/", 16'h0};
            6'd4:  w = {"%", 16'h0};
            6'd5:  w = {"=", 16'h0};
            6'd6:  w = {"==", 8'h0};
            6'd7:  w = {"!=", 8'h0};
            6'd8:  w = {">", 16'h0};
            6'd9:  w = {"<", 16'h0};
            6'd10: w = {">=", 8'h0};
            6'd11: w = {"<=", 8'h0};
            6'd12: w = {"&&", 8'h0};
            6'd13: w = {"||", 8'h0};
            6'd14: w = {"!", 16'h0};
            6'd15: w = {"&", 16'h0};
            6'd16: w = {"|", 16'h0};
            6'd17: w = {"^", 16'h0};
            6'd18: w = {"~", 16'h0};
            6'd19: w = {"<<", 8'h0};
            6'd20: w = {">>", 8'h0};
            6'd21: w = {"+=", 8'h0};
            6'd22: w = {"-=", 8'h0};
            6'd23: w = {"*=", 8'h0};
            6'd24: w = {"/=", 8'h0};
            6'd25: w = {"%=", 8'h0};
            6'd26: w = {"&=", 8'h0};
            6'd27: w = {"|=", 8'h0};
            6'd28: w = {"^=", 8'h0};
            6'd29: w = "<<=";
            6'd30: w = ">>=";
            6'd31: w = {"++", 8'h0};
            6'd32: w = {"--", 8'h0};
            6'd33: w = {"->", 8'h0};
            6'd34: w = {".", 16'h0};
            6'd35: w = {"?", 16'h0};
            6'd36: w = {":", 16'h0};
            default: w = {",", 16'h0};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [3:0] pos);
        logic [71:0] w;
        logic [7:0]  ch;
        w  = kw_word(idx);
        ch = 8'h0;
        for (int k = 0; k < KW_CHARS; k++) begin
            if (pos == 4'(k)) ch = w[71 - 8 * k -: 8];
        end
        return ch;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] idx);
        logic [71:0] w;
        logic [3:0]  n;
        w = kw_word(idx);
        n = 4'd0;
        for (int k = 0; k < KW_CHARS; k++) begin
            if (w[71 - 8 * k -: 8] != 8'h0) n = n + 4'd1;
        end
        return n;
    endfunction

    function automatic logic [7:0] op_char(input logic [5:0] idx, input logic [3:0] pos);
        logic [23:0] w;
        logic [7:0]  ch;
        w  = op_word(idx);
        ch = 8'h0;
        for (int k = 0; k < OP_CHARS; k++) begin
            if (pos == 4'(k)) ch = w[23 - 8 * k -: 8];
        end
        return ch;
    endfunction

    function automatic logic [3:0] op_len(input logic [5:0] idx);
        logic [23:0] w;
        logic [3:0]  n;
        w = op_word(idx);
        n = 4'd0;
        for (int k = 0; k < OP_CHARS; k++) begin
            if (w[23 - 8 * k -: 8] != 8'h0) n = n + 4'd1;
        end
        return n;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        return c == "(" || c == ")" || c == "," || c == ";" || c == ":" ||
               c == "{" || c == "}" || c == "[" || c == "]" || c == "#" ||
               c == 8'h22 || c == 8'h27 || c == 8'h5c || c == ".";
    endfunction

endpackage

@@ rtl/core/c_token_classifier_core.sv @@
// Classifies C tokens that arrive one character per request, the last character
// flagged by token_end. Each character updates keyword and operator match masks
// and a few scan flags as it is accepted, so a character can be accepted in every
// cycle that the input is not stalled; the class of a token is loaded into the result
// register when its last character is accepted. Input stalls only while a result waits
// and the output is stalled.
module c_token_classifier_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_code,
    input  logic       token_end,
    output logic       class_valid,
    input  logic       class_stall,
    output logic [2:0] token_class,
    output logic [2:0] error_kind
);
    import ctc_pkg::*;

    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic [31:0] kw_reg, kw_next;
    logic [37:0] op_reg, op_next;
    logic        ident_reg, ident_next;
    logic        hex_ok_reg, hex_ok_next;
    logic        bin_ok_reg, bin_ok_next;
    logic        oct_ok_reg, oct_ok_next;
    logic        dot_reg, dot_next;
    logic        ns_dot_reg, ns_dot_next;
    logic        ns_exp_reg, ns_exp_next;
    logic        ns_dig_reg, ns_dig_next;
    logic        ns_err_reg, ns_err_next;
    logic        ns_ae_reg, ns_ae_next;
    logic        ns_as_reg, ns_as_next;
    logic        out_valid_reg, out_valid_next;
    class_t      cls_reg, cls_next;
    err_t        err_reg, err_next;

    logic        accept;
    logic [4:0]  n_len;
    logic [7:0]  c0, c1;
    logic        kw_hit, op_hit, starts;

    assign char_stall  = out_valid_reg & class_stall;
    assign accept      = char_valid & ~char_stall;
    assign class_valid = out_valid_reg;
    assign token_class = cls_reg;
    assign error_kind  = err_reg;

    always_comb
    begin
        kw_next = kw_reg;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (kw_char(5'(i), pos_reg) == 8'h0 || kw_char(5'(i), pos_reg) != char_code)
                kw_next[i] = 1'b0;
        end
        op_next = op_reg;
        for (int i = 0; i < OP_COUNT; i++)
        begin
            if (op_char(6'(i), pos_reg) == 8'h0 || op_char(6'(i), pos_reg) != char_code)
                op_next[i] = 1'b0;
        end

        ident_next = ident_reg;
        if (pos_reg == 4'd0)
        begin
            if (!(is_alpha(char_code) || char_code == "_")) ident_next = 1'b0;
        end
        else if (!(is_alpha(char_code) || is_digit(char_code) || char_code == "_"))
        begin
            ident_next = 1'b0;
        end
        hex_ok_next = hex_ok_reg & ~(pos_reg >= 4'd2 && !is_xdigit(char_code));
        bin_ok_next = bin_ok_reg & ~(pos_reg >= 4'd2 && char_code != "0" && char_code != "1");
        oct_ok_next = oct_ok_reg & ~(pos_reg >= 4'd1 && (char_code < "0" || char_code > "7"));
        dot_next    = dot_reg | (char_code == ".");

        ns_dot_next = ns_dot_reg;
        ns_exp_next = ns_exp_reg;
        ns_dig_next = ns_dig_reg;
        ns_err_next = ns_err_reg;
        ns_ae_next  = ns_ae_reg;
        ns_as_next  = ns_as_reg;
        if (!ns_err_reg)
        begin
            if (ns_ae_reg)
            begin
                ns_ae_next = 1'b0;
                if (char_code == "+" || char_code == "-") ns_as_next = 1'b1;
                else if (!is_digit(char_code)) ns_err_next = 1'b1;
            end
            else if (ns_as_reg)
            begin
                ns_as_next = 1'b0;
                if (!is_digit(char_code)) ns_err_next = 1'b1;
            end
            else if (is_digit(char_code))
            begin
                ns_dig_next = 1'b1;
            end
            else if (char_code == "." && !ns_dot_reg)
            begin
                ns_dot_next = 1'b1;
            end
            else if ((char_code == "e" || char_code == "E") && ns_dig_reg && !ns_exp_reg)
            begin
                ns_exp_next = 1'b1;
                ns_ae_next  = 1'b1;
            end
            else if (!(pos_reg == 4'd0 && (char_code == "+" || char_code == "-")))
            begin
                ns_err_next = 1'b1;
            end
        end

        n_len  = {1'b0, pos_reg} + 5'd1;
        kw_hit = 1'b0;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (kw_next[i] && {1'b0, kw_len(5'(i))} == n_len) kw_hit = 1'b1;
        end
        op_hit = 1'b0;
        for (int i = 0; i < OP_COUNT; i++)
        begin
            if (op_next[i] && {1'b0, op_len(6'(i))} == n_len) op_hit = 1'b1;
        end
        c0 = (pos_reg == 4'd0) ? char_code : first_reg;
        c1 = (pos_reg == 4'd0) ? 8'h0 : ((pos_reg == 4'd1) ? char_code : second_reg);
        starts = is_digit(c0) || c0 == 8'h27 || c0 == 8'h22 ||
                 ((c0 == "+" || c0 == "-") && is_digit(c1));

        err_next = ERR_NONE;
        if (kw_hit)
        begin
            cls_next = CLS_KEYWORD;
        end
        else if (ident_next)
        begin
            cls_next = CLS_IDENT;
        end
        else if (starts)
        begin
            if (c0 == 8'h22 && char_code == 8'h22)
            begin
                cls_next = CLS_CONST;
            end
            else if (c0 == 8'h27 && char_code == 8'h27)
            begin
                if (pos_reg == 4'd2 || (pos_reg == 4'd3 && c1 == 8'h5c))
                begin
                    cls_next = CLS_CONST;
                end
                else
                begin
                    cls_next = CLS_BAD;
                    err_next = ERR_CHAR;
                end
            end
            else if (pos_reg >= 4'd2 && c0 == "0" && (c1 == "x" || c1 == "X"))
            begin
                cls_next = hex_ok_next ? CLS_CONST : CLS_BAD;
                err_next = hex_ok_next ? ERR_NONE : ERR_HEX;
            end
            else if (pos_reg >= 4'd2 && c0 == "0" && (c1 == "b" || c1 == "B"))
            begin
                cls_next = bin_ok_next ? CLS_CONST : CLS_BAD;
                err_next = bin_ok_next ? ERR_NONE : ERR_BIN;
            end
            else if (c0 == "0" && pos_reg >= 4'd1 && !dot_next && c1 != "x" && c1 != "X"
                     && c1 != "b" && c1 != "B")
            begin
                cls_next = oct_ok_next ? CLS_CONST : CLS_BAD;
                err_next = oct_ok_next ? ERR_NONE : ERR_OCT;
            end
            else if (!ns_err_next && !ns_ae_next && !ns_as_next && ns_dig_next)
            begin
                cls_next = CLS_CONST;
            end
            else
            begin
                cls_next = CLS_BAD;
                err_next = ERR_NUM;
            end
        end
        else if (op_hit)
        begin
            cls_next = CLS_OPER;
        end
        else if (pos_reg == 4'd0 && is_special(char_code))
        begin
            cls_next = CLS_SPECIAL;
        end
        else
        begin
            cls_next = CLS_UNKNOWN;
        end

        first_next  = (pos_reg == 4'd0) ? char_code : first_reg;
        second_next = (pos_reg == 4'd1) ? char_code : second_reg;
        pos_next    = (pos_reg == 4'd15) ? pos_reg : pos_reg + 4'd1;

        out_valid_next = out_valid_reg & class_stall;
        if (accept && token_end) out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 4'd0;
            first_reg     <= 8'h0;
            second_reg    <= 8'h0;
            kw_reg        <= '1;
            op_reg        <= '1;
            ident_reg     <= 1'b1;
            hex_ok_reg    <= 1'b1;
            bin_ok_reg    <= 1'b1;
            oct_ok_reg    <= 1'b1;
            dot_reg       <= 1'b0;
            ns_dot_reg    <= 1'b0;
            ns_exp_reg    <= 1'b0;
            ns_dig_reg    <= 1'b0;
            ns_err_reg    <= 1'b0;
            ns_ae_reg     <= 1'b0;
            ns_as_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept && token_end)
            begin
                pos_reg    <= 4'd0;
                first_reg  <= 8'h0;
                second_reg <= 8'h0;
                kw_reg     <= '1;
                op_reg     <= '1;
                ident_reg  <= 1'b1;
                hex_ok_reg <= 1'b1;
                bin_ok_reg <= 1'b1;
                oct_ok_reg <= 1'b1;
                dot_reg    <= 1'b0;
                ns_dot_reg <= 1'b0;
                ns_exp_reg <= 1'b0;
                ns_dig_reg <= 1'b0;
                ns_err_reg <= 1'b0;
                ns_ae_reg  <= 1'b0;
                ns_as_reg  <= 1'b0;
            end
            else if (accept)
            begin
                pos_reg    <= pos_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                kw_reg     <= kw_next;
                op_reg     <= op_next;
                ident_reg  <= ident_next;
                hex_ok_reg <= hex_ok_next;
                bin_ok_reg <= bin_ok_next;
                oct_ok_reg <= oct_ok_next;
                dot_reg    <= dot_next;
                ns_dot_reg <= ns_dot_next;
                ns_exp_reg <= ns_exp_next;
                ns_dig_reg <= ns_dig_next;
                ns_err_reg <= ns_err_next;
                ns_ae_reg  <= ns_ae_next;
                ns_as_reg  <= ns_as_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg <= CLS_KEYWORD;
            err_reg <= ERR_NONE;
        end
        else if (accept && token_end)
        begin
            cls_reg <= cls_next;
            err_reg <= err_next;
        end
    end

    a_err_only_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((err_reg != ERR_NONE) == (cls_reg == CLS_BAD)))
        else $error("error kind does not agree with class");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && token_end) |=> out_valid_reg)
        else $error("token end gave no result");

    a_end_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && token_end) |=> (pos_reg == 4'd0 && kw_reg == '1))
        else $error("token state not cleared after token end");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !(accept && token_end)) |=> !out_valid_reg)
        else $error("result appeared without a token end");

endmodule
